// ===== rtl/vpp_pkg.sv =====
// ----------------------------------------------------------------------------
// vpp_pkg
// Shared types and codes of the vibration pattern player.
// ----------------------------------------------------------------------------
package vpp_pkg;

  // Default slot count of the phase memory
  localparam int MAX_PHASES_DEF = 16;

  // Field widths of one item
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int FRAMES_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int LEN_W    = 5;

  // Stream widths (tdata padded to whole bytes)
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // Item kinds carried in tuser
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // One phase slot as held in memory
  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [FRAMES_W-1:0] frames;
  } phase_entry_t;

endpackage

// ===== rtl/vibration_pattern_player.sv =====
// ----------------------------------------------------------------------------
// vibration_pattern_player
// Rumble pattern player: phase slot memory plus a phase sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries items; tuser selects write, start or frame tick.
//   A write transfer stores frame count and motor word into a phase slot.
//   A start transfer (link stable, nonzero length) begins at phase 0; each
//   stable tick counts down the current phase and moves on when it runs out,
//   clearing the motor word after the last phase.
//   Every item yields exactly one master transfer with motor word, playing
//   flag and current phase index.
// Timing:
//   An item passes the execute stage and then the output register. Throughput
//   is one item per cycle while results are taken: the memory read for an
//   item is issued at intake, addressed from the phase index that the item
//   ahead is about to leave. The read data is registered in the memory.
// Reset and stall:
//   Reset stops playback, zeroes the motor word and empties the pipeline;
//   slot contents are undefined until written. When the receiver stalls the
//   result holds in the output register; the next item still enters the
//   execute stage, after which tready drops until the result is taken.
// ----------------------------------------------------------------------------
module vibration_pattern_player #(
  parameter int MAX_PHASES = vpp_pkg::MAX_PHASES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] entry_index, [19:4] entry_frames, [35:20] entry_level,
  // [40:36] pattern_length, [41] link_stable, [47:42] zero
  input  logic [vpp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [vpp_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] motor_word, [16] playing, [21:17] phase_now, [23:22] zero
  output logic [vpp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;

  // Memory port between sequencer and slot store
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  vpp_pkg::phase_entry_t mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  vpp_pkg::phase_entry_t mem_rdata;

  vpp_phase_mem #(
    .MAX_PHASES(MAX_PHASES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  vpp_engine #(
    .MAX_PHASES(MAX_PHASES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

`ifndef SYNTHESIS
  // An idle player never drives the motors
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("motor word nonzero while not playing");

  // A playing phase always lies inside the slot memory
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16] |-> int'(m_axis_tdata[21:17]) < MAX_PHASES)
    else $error("playing phase outside slot range");

  // Intake only backs up behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");
`endif

endmodule

// ===== rtl/vpp_phase_mem.sv =====
// ----------------------------------------------------------------------------
// vpp_phase_mem
// Phase slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vpp_phase_mem #(
  parameter int MAX_PHASES = vpp_pkg::MAX_PHASES_DEF,
  localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  vpp_pkg::phase_entry_t wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output vpp_pkg::phase_entry_t rdata
);

  vpp_pkg::phase_entry_t mem [MAX_PHASES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vpp_engine.sv =====
// ----------------------------------------------------------------------------
// vpp_engine
// Item intake, phase sequencing state and output register.
// ----------------------------------------------------------------------------
module vpp_engine #(
  parameter int MAX_PHASES = vpp_pkg::MAX_PHASES_DEF,
  localparam int AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [vpp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [vpp_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [vpp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output vpp_pkg::phase_entry_t          mem_wdata,
  output logic                           mem_re,
  output logic [AW-1:0]                  mem_raddr,
  input  vpp_pkg::phase_entry_t          mem_rdata
);

  localparam int LW = vpp_pkg::LEN_W;
  localparam int FW = vpp_pkg::FRAMES_W;

  // Unpacked input fields
  logic [vpp_pkg::SLOT_W-1:0]   in_slot;
  logic [vpp_pkg::FRAMES_W-1:0] in_frames;
  logic [vpp_pkg::LEVEL_W-1:0]  in_level;
  logic [LW-1:0]                in_len;
  logic                         in_stable;
  logic                         accept;

  // Execute stage
  logic                         s1_valid;
  logic [vpp_pkg::KIND_W-1:0]   s1_kind;
  logic [LW-1:0]                s1_len;
  logic                         s1_stable;
  logic                         s1_adv;

  // Sequencing state
  logic [LW-1:0]                active_length, active_length_next;
  logic [LW-1:0]                phase_index, phase_index_next;
  logic [vpp_pkg::FRAMES_W-1:0] frames_left, frames_left_next;
  logic                         active_flag, active_flag_next;
  logic [vpp_pkg::LEVEL_W-1:0]  drive_word, drive_word_next;

  logic [LW-1:0]                phase_inc;
  logic [LW-1:0]                phase_eff;
  logic [LW-1:0]                phase_eff_inc;
  logic [LW-1:0]                len_sat;
  logic [vpp_pkg::FRAMES_W-1:0] frames_loaded;

  // Output register
  logic                         out_valid;
  logic [vpp_pkg::LEVEL_W-1:0]  out_word;
  logic                         out_playing;
  logic [LW-1:0]                out_phase;

  assign in_slot   = s_axis_tdata[3:0];
  assign in_frames = s_axis_tdata[19:4];
  assign in_level  = s_axis_tdata[35:20];
  assign in_len    = s_axis_tdata[40:36];
  assign in_stable = s_axis_tdata[41];

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Write slots at intake; later items read at their own intake and see the update.
  assign mem_we    = accept && (s_axis_tuser == vpp_pkg::KIND_WRITE)
                     && (int'(in_slot) < MAX_PHASES);
  assign mem_waddr = AW'(in_slot);
  assign mem_wdata = '{level: in_level, frames: in_frames};

  // Prefetch phase 0 for a start, else the slot after the phase that the
  // item ahead leaves behind.
  assign phase_eff     = s1_valid ? phase_index_next : phase_index;
  assign phase_eff_inc = phase_eff + LW'(1);
  assign mem_re        = accept;
  assign mem_raddr     = (s_axis_tuser == vpp_pkg::KIND_START) ? '0 : AW'(phase_eff_inc);

  assign phase_inc = phase_index + LW'(1);
  assign len_sat   = (int'(s1_len) > MAX_PHASES) ? LW'(MAX_PHASES) : s1_len;

  always_comb begin
    active_length_next = active_length;
    phase_index_next   = phase_index;
    frames_left_next   = frames_left;
    active_flag_next   = active_flag;
    drive_word_next    = drive_word;
    frames_loaded      = frames_left;
    unique case (s1_kind)
      vpp_pkg::KIND_START: begin
        if (s1_stable && (s1_len != '0)) begin
          active_length_next = len_sat;
          phase_index_next   = '0;
          frames_left_next   = mem_rdata.frames;
          drive_word_next    = mem_rdata.level;
          active_flag_next   = 1'b1;
        end
      end
      vpp_pkg::KIND_TICK: begin
        if (s1_stable && active_flag) begin
          if (frames_left == '0) begin
            phase_index_next = phase_inc;
            if (phase_inc >= active_length) begin
              active_flag_next = 1'b0;
              drive_word_next  = '0;
            end else begin
              frames_loaded   = mem_rdata.frames;
              drive_word_next = mem_rdata.level;
            end
          end
          if (!((frames_left == '0) && (phase_inc >= active_length))) begin
            // saturate the countdown at zero
            frames_left_next = (frames_loaded != '0) ? frames_loaded - FW'(1) : '0;
          end
        end
      end
      default: begin
        // writes and unused kinds leave the state alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind   <= s_axis_tuser;
      s1_len    <= in_len;
      s1_stable <= in_stable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= '0;
      phase_index   <= '0;
      frames_left   <= '0;
      active_flag   <= 1'b0;
      drive_word    <= '0;
    end else if (s1_adv) begin
      active_length <= active_length_next;
      phase_index   <= phase_index_next;
      frames_left   <= frames_left_next;
      active_flag   <= active_flag_next;
      drive_word    <= drive_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word    <= drive_word_next;
      out_playing <= active_flag_next;
      out_phase   <= phase_index_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_phase, out_playing, out_word};

endmodule
